// ----- sv/htwl_pkg.sv -----
// ----------------------------------------------------------------------------
// htwl_pkg
// Shared types and constants for the hex text word loader.
// ----------------------------------------------------------------------------
package htwl_pkg;

    localparam logic [31:0] LOAD_BASE_RESET = 32'h8000_1000;
    localparam logic [31:0] ADDR_STEP       = 32'd4;

    localparam logic [7:0] CH_HASH     = 8'h23;
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_F  = 8'h66;
    localparam logic [7:0] CASE_BIT    = 8'h20;
    localparam logic [7:0] HEX_A_OFS   = 8'h57;

    typedef struct packed {
        logic       is_newline;
        logic       is_hash;
        logic       is_skip;
        logic       is_hex;
        logic       is_bad;
        logic [3:0] nibble;
    } char_info_t;

endpackage

// ----- sv/htwl_char_decode.sv -----
// ----------------------------------------------------------------------------
// htwl_char_decode
// Classifies one received character and gives its hex nibble value.
// ----------------------------------------------------------------------------
module htwl_char_decode (
    input  logic [7:0]          rx_byte,
    output htwl_pkg::char_info_t info
);
    import htwl_pkg::*;

    logic [7:0] lower;
    logic [7:0] letter_val;

    assign lower      = rx_byte | CASE_BIT;
    assign letter_val = lower - HEX_A_OFS;

    always_comb begin
        info            = '0;
        info.is_newline = (rx_byte == CH_NEWLINE);
        info.is_hash    = (rx_byte == CH_HASH);
        if (rx_byte < CH_ZERO) begin
            info.is_skip = 1'b1;
        end else if (rx_byte inside {[CH_ZERO:CH_NINE]}) begin
            info.is_hex = 1'b1;
            info.nibble = rx_byte[3:0];
        end else if (lower inside {[CH_LOWER_A:CH_LOWER_F]}) begin
            info.is_hex = 1'b1;
            info.nibble = letter_val[3:0];
        end else begin
            info.is_bad = 1'b1;
        end
    end

endmodule

// ----- sv/hex_text_word_loader.sv -----
// ----------------------------------------------------------------------------
// hex_text_word_loader
// Assembles 32-bit words with write addresses from an ASCII hex text stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_rx_byte carries one text character per item.
//   m_valid/m_ready carries a result item: m_write_address, m_write_data,
//   m_bad_char. '#' opens a comment up to newline; bytes below '0' are
//   skipped; hex digits pair into bytes, four bytes (first in bits 7:0)
//   form a word. Any other character gives one item with m_bad_char set
//   and the block then ignores all input until reset.
//   Each character is handled in the cycle it is accepted; a result item
//   is registered and visible in the cycle after the character that completes it.
//   Throughput is one character per cycle, set by the single output
//   register; s_ready stays high while that register is empty or being
//   drained, so a stalled receiver holds the input only when a result is
//   waiting.
//   cfg_wr_en/cfg_wr_data write load_base and reload the running address.
//   Reset (aresetn low, synchronous) clears all parse state, sets load_base
//   to 0x80001000 and empties the output register.
// ----------------------------------------------------------------------------
module hex_text_word_loader (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_write_address,
    output logic [31:0] m_write_data,
    output logic        m_bad_char
);
    import htwl_pkg::*;

    char_info_t  info;

    logic        in_comment_reg,  in_comment_next;
    logic        low_nib_reg,     low_nib_next;
    logic [3:0]  high_nib_reg,    high_nib_next;
    logic [23:0] partial_reg,     partial_next;
    logic [1:0]  bytes_held_reg,  bytes_held_next;
    logic [31:0] next_addr_reg,   next_addr_next;
    logic [31:0] load_base_reg;
    logic        halted_reg,      halted_next;

    logic        m_valid_reg,     m_valid_next;
    logic [31:0] m_addr_reg,      m_addr_next;
    logic [31:0] m_data_reg,      m_data_next;
    logic        m_bad_reg,       m_bad_next;

    logic        accept;
    logic        emit;
    logic [7:0]  byte_val;

    htwl_char_decode u_decode (
        .rx_byte (s_rx_byte),
        .info    (info)
    );

    assign s_ready  = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign byte_val = {high_nib_reg, info.nibble};

    always_comb begin
        in_comment_next = in_comment_reg;
        low_nib_next    = low_nib_reg;
        high_nib_next   = high_nib_reg;
        partial_next    = partial_reg;
        bytes_held_next = bytes_held_reg;
        next_addr_next  = next_addr_reg;
        halted_next     = halted_reg;
        emit            = 1'b0;
        m_addr_next     = m_addr_reg;
        m_data_next     = m_data_reg;
        m_bad_next      = m_bad_reg;

        if (accept && !halted_reg) begin
            if (in_comment_reg) begin
                if (info.is_newline) begin
                    in_comment_next = 1'b0;
                end
            end else if (info.is_hash) begin
                in_comment_next = 1'b1;
            end else if (info.is_bad) begin
                halted_next = 1'b1;
                emit        = 1'b1;
                m_addr_next = '0;
                m_data_next = '0;
                m_bad_next  = 1'b1;
            end else if (info.is_hex) begin
                if (!low_nib_reg) begin
                    high_nib_next = info.nibble;
                    low_nib_next  = 1'b1;
                end else begin
                    low_nib_next = 1'b0;
                    if (bytes_held_reg == 2'd3) begin
                        emit            = 1'b1;
                        m_addr_next     = next_addr_reg;
                        m_data_next     = {byte_val, partial_reg};
                        m_bad_next      = 1'b0;
                        next_addr_next  = next_addr_reg + ADDR_STEP;
                        partial_next    = '0;
                        bytes_held_next = 2'd0;
                    end else begin
                        case (bytes_held_reg)
                            2'd0:    partial_next[7:0]   = byte_val;
                            2'd1:    partial_next[15:8]  = byte_val;
                            2'd2:    partial_next[23:16] = byte_val;
                            default: partial_next        = partial_reg;
                        endcase
                        bytes_held_next = bytes_held_reg + 2'd1;
                    end
                end
            end
        end

        if (cfg_wr_en) begin
            next_addr_next = cfg_wr_data;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (emit) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_comment_reg <= 1'b0;
            low_nib_reg    <= 1'b0;
            high_nib_reg   <= '0;
            partial_reg    <= '0;
            bytes_held_reg <= '0;
            next_addr_reg  <= LOAD_BASE_RESET;
            load_base_reg  <= LOAD_BASE_RESET;
            halted_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            in_comment_reg <= in_comment_next;
            low_nib_reg    <= low_nib_next;
            high_nib_reg   <= high_nib_next;
            partial_reg    <= partial_next;
            bytes_held_reg <= bytes_held_next;
            next_addr_reg  <= next_addr_next;
            halted_reg     <= halted_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_wr_en) begin
                load_base_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_addr_reg <= m_addr_next;
        m_data_reg <= m_data_next;
        m_bad_reg  <= m_bad_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_write_address = m_addr_reg;
    assign m_write_data    = m_data_reg;
    assign m_bad_char      = m_bad_reg;

    // load_base feeds nothing in the datapath; a write loads it and the running address alike
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> (next_addr_reg == load_base_reg))
        else $error("address not reloaded from load_base");

    assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |=> halted_reg)
        else $error("halt released without reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (halted_reg && !m_valid_reg) |=> !m_valid_reg)
        else $error("item produced while halted");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_bad_reg) |-> (m_addr_reg == '0 && m_data_reg == '0))
        else $error("error item carries nonzero payload");

endmodule

// ----- test/hex_text_word_loader_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_text_word_loader_tb
// Checks the hex text loader against a cycle-free model of its parser: text
// items go in with random gaps, result items come out with random stalls,
// and every result is compared field by field with the predicted word write.
// ----------------------------------------------------------------------------
module hex_text_word_loader_tb;
    import htwl_pkg::*;

    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] data;
        logic        bad;
    } word_write_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte   = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [31:0] m_write_address;
    logic [31:0] m_write_data;
    logic        m_bad_char;

    bit calm        = 1'b0;
    int mismatches  = 0;
    int digits_sent = 0;

    word_write_t word_writes_due[$];

    // parser state mirror
    logic        cmt_open   = 1'b0;
    logic        want_low   = 1'b0;
    logic [3:0]  hi_nib     = '0;
    logic [23:0] held_bytes = '0;
    logic [1:0]  held_count = '0;
    logic [31:0] next_addr  = LOAD_BASE_RESET;
    logic        stopped    = 1'b0;

    always #4 aclk = ~aclk;

    hex_text_word_loader dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_write_address (m_write_address),
        .m_write_data    (m_write_data),
        .m_bad_char      (m_bad_char)
    );

    function automatic void predict_char(input logic [7:0] c);
        logic [7:0] lc;
        logic [3:0] nib;
        logic [7:0] b;
        if (stopped) return;
        if (cmt_open) begin
            if (c == CH_NEWLINE) cmt_open = 1'b0;
            return;
        end
        if (c == CH_HASH) begin
            cmt_open = 1'b1;
            return;
        end
        if (c < CH_ZERO) return;
        if (c <= CH_NINE) begin
            nib = 4'(c - CH_ZERO);
        end else begin
            lc = c | CASE_BIT;
            if (lc < CH_LOWER_A || lc > CH_LOWER_F) begin
                stopped = 1'b1;
                word_writes_due.push_back('{addr: '0, data: '0, bad: 1'b1});
                return;
            end
            nib = 4'(lc - HEX_A_OFS);
        end
        if (!want_low) begin
            hi_nib   = nib;
            want_low = 1'b1;
            return;
        end
        want_low = 1'b0;
        b = {hi_nib, nib};
        if (held_count == 2'd3) begin
            word_writes_due.push_back('{addr: next_addr, data: {b, held_bytes}, bad: 1'b0});
            next_addr  = next_addr + ADDR_STEP;
            held_bytes = '0;
            held_count = '0;
        end else begin
            held_bytes = held_bytes | (24'(b) << (held_count * 8));
            held_count = held_count + 2'd1;
        end
    endfunction

    task automatic send_char(input logic [7:0] c);
        if (!calm && $urandom_range(0, 9) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= c;
        do @(posedge aclk); while (!s_ready);
        predict_char(c);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    task automatic drain_writes();
        s_valid <= 1'b0;
        do @(posedge aclk); while (word_writes_due.size() != 0);
    endtask

    task automatic write_base(input logic [31:0] v);
        drain_writes();
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        next_addr = v;
    endtask

    task automatic send_hex_digit(input logic [3:0] v);
        logic [7:0] c;
        if (v < 4'd10)
            c = CH_ZERO + 8'(v);
        else if ($urandom_range(0, 1) != 0)
            c = CH_LOWER_A + 8'(v) - 8'd10;
        else
            c = (CH_LOWER_A & ~CASE_BIT) + 8'(v) - 8'd10;
        send_char(c);
        digits_sent++;
    endtask

    task automatic send_noise();
        logic [7:0] c;
        int n;
        case ($urandom_range(0, 3))
            0: begin
                do c = 8'($urandom_range(0, CH_ZERO - 1)); while (c == CH_HASH);
                send_char(c);
            end
            1: send_char(CH_NEWLINE);
            default: begin
                send_char(CH_HASH);
                n = $urandom_range(0, 6);
                repeat (n) begin
                    do c = 8'($urandom_range(0, 255)); while (c == CH_NEWLINE);
                    send_char(c);
                end
                send_char(CH_NEWLINE);
            end
        endcase
    endtask

    task automatic send_rand_word();
        logic [31:0] w;
        case ($urandom_range(0, 15))
            0: w = '0;
            1: w = '1;
            default: w = $urandom;
        endcase
        for (int i = 0; i < 4; i++) begin
            for (int h = 1; h >= 0; h--) begin
                if ($urandom_range(0, 11) == 0) send_noise();
                send_hex_digit(w[8*i + 4*h +: 4]);
            end
        end
    endtask

    task automatic test_directed_text();
        send_text("01/23");
        send_char(8'h00);
        send_text("45\n67");
        send_char(CH_HASH);
        send_char(8'h80);
        send_char(8'hFF);
        send_text("g\n");
        send_text("89aBcDeF");
    endtask

    // base rewritten with a byte half built and a comment open
    task automatic test_base_reload();
        send_text("12345#zz");
        write_base(32'h0000_0000);
        send_text("\n678");
        write_base(32'hFFFF_FFFC);
        repeat (2) send_rand_word();
        write_base(32'hFFFF_FFFE);
        repeat (2) send_rand_word();
    endtask

    task automatic test_random_stream();
        int target;
        for (int phase = 0; phase < 4; phase++) begin
            if (phase == 1)
                write_base($urandom);
            else
                write_base($urandom & 32'hFFFF_FFFC);
            calm = (phase == 3);
            target = digits_sent + 320;
            while (digits_sent < target) begin
                if ($urandom_range(0, 6) == 0)
                    send_noise();
                else
                    send_rand_word();
                if ($urandom_range(0, 59) == 0) drain_writes();
            end
        end
    endtask

    task automatic test_halt_on_bad_char();
        logic [7:0] c;
        send_text("5");
        if ($urandom_range(0, 1) != 0)
            c = 8'($urandom_range(8'h80, 8'hFF));
        else
            do c = 8'($urandom_range(CH_NINE + 1, 8'h7F));
            while ((c | CASE_BIT) >= CH_LOWER_A && (c | CASE_BIT) <= CH_LOWER_F);
        send_char(c);
        repeat (24) send_char(8'($urandom_range(0, 255)));
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_text();
        test_base_reload();
        test_random_stream();
        test_halt_on_bad_char();
        drain_writes();
        repeat (16) @(posedge aclk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        int stall;
        forever begin
            @(posedge aclk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                stall = $urandom_range(1, 9);
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        word_write_t w;
        if (aresetn && m_valid && m_ready) begin
            if (word_writes_due.size() == 0) begin
                $error("unexpected item: address %h data %h bad_char %b",
                       m_write_address, m_write_data, m_bad_char);
                mismatches++;
            end else begin
                w = word_writes_due.pop_front();
                if (m_write_address !== w.addr) begin
                    $error("write_address: expected %h, actual %h", w.addr, m_write_address);
                    mismatches++;
                end
                if (m_write_data !== w.data) begin
                    $error("write_data: expected %h, actual %h", w.data, m_write_data);
                    mismatches++;
                end
                if (m_bad_char !== w.bad) begin
                    $error("bad_char: expected %b, actual %b", w.bad, m_bad_char);
                    mismatches++;
                end
            end
        end
    end

endmodule
